/* rtl/kts_pkg.sv */
// ----------------------------------------------------------------------------
// kts_pkg
// shared types and constants for the k-th smallest threshold selector
// ----------------------------------------------------------------------------
package kts_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 11;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    // word index of the rank register
    localparam logic [ADDR_W-3:0] RANK_IDX = '0;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } cell_data_t;

    typedef enum logic {
        ST_COLLECT,
        ST_SELECT
    } state_t;

endpackage

/* rtl/kth_smallest_threshold_select.sv */
// ----------------------------------------------------------------------------
// kth_smallest_threshold_select
// finds a threshold with exactly k values of a set at or below it
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  sample    in         sample_valid / sample_ready     sample_value, is_last
//  result    out        result_valid / result_ready     found, threshold
//  apb       in         psel, penable, pwrite, pready   paddr, pwdata, prdata
//
//  one item per cycle while a set is being collected; each item is inserted
//  into the sorted cell row in the cycle it is accepted, while the row has room
//  after the last item the row shifts toward its head k-1 times when
//  1 <= k < n; the result is then registered once the output is free
//  reset clears the cell valid bits at once; no clearing pass
//  a stalled result holds; new items are taken while it waits
// ----------------------------------------------------------------------------
module kth_smallest_threshold_select #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_ready,
    input  logic [kts_pkg::VALUE_W-1:0]  sample_value,
    input  logic                         is_last,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic                         found,
    output logic [kts_pkg::VALUE_W-1:0]  threshold,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kts_pkg::ADDR_W-1:0]   paddr,
    input  logic [kts_pkg::DATA_W-1:0]   pwdata,
    output logic [kts_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import kts_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    state_t             state_reg;
    state_t             state_next;
    logic [RANK_W-1:0]  rank_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   scan_reg;
    logic [VALUE_W-1:0] largest_reg;
    logic               overflow_reg;
    logic               result_valid_reg;
    logic               found_reg;
    logic [VALUE_W-1:0] threshold_reg;

    cell_ctrl_t         ctrl;
    cell_data_t         head0;
    cell_data_t         head1;

    logic               accept;
    logic               room;
    logic               emit;
    logic               out_free;
    logic [CMP_W-1:0]   k_ext;
    logic [CMP_W-1:0]   n_ext;
    logic [CMP_W-1:0]   scan_ext;
    logic               rank_over;
    logic               rank_eq;
    logic               rank_zero;
    logic               general;
    logic               at_target;
    logic               res_found;
    logic [VALUE_W-1:0] res_threshold;
    logic               cfg_write;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[ADDR_W-1:2] == RANK_IDX);
    assign prdata    = (paddr[ADDR_W-1:2] == RANK_IDX) ? DATA_W'(rank_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
        end
        else if (cfg_write)
        begin
            rank_reg <= pwdata[RANK_W-1:0];
        end
    end

    // result case decision
    assign k_ext     = CMP_W'(rank_reg);
    assign n_ext     = CMP_W'(count_reg);
    assign scan_ext  = CMP_W'(scan_reg);
    assign rank_over = overflow_reg || (k_ext > n_ext);
    assign rank_eq   = (k_ext == n_ext);
    assign rank_zero = (rank_reg == '0);
    assign general   = !rank_over && !rank_eq && !rank_zero;
    assign at_target = (scan_ext == (k_ext - CMP_W'(1)));
    assign room      = (count_reg < CNT_W'(MAX_ITEMS));
    assign out_free  = !result_valid_reg || result_ready;

    always_comb
    begin
        res_found     = 1'b0;
        res_threshold = '0;
        if (rank_over)
        begin
            res_found = 1'b0;
        end
        else if (rank_eq)
        begin
            res_found     = 1'b1;
            res_threshold = largest_reg;
        end
        else if (rank_zero)
        begin
            if (head0.value > VALUE_W'(1))
            begin
                res_found     = 1'b1;
                res_threshold = VALUE_W'(1);
            end
        end
        else if (head0.value != head1.value)
        begin
            res_found     = 1'b1;
            res_threshold = head0.value;
        end
    end

    // control outputs
    always_comb
    begin
        sample_ready = 1'b0;
        accept       = 1'b0;
        emit         = 1'b0;
        ctrl         = '0;
        case (state_reg)
            ST_COLLECT:
            begin
                sample_ready = 1'b1;
                accept       = sample_valid;
                ctrl.insert  = sample_valid && room;
            end
            ST_SELECT:
            begin
                if (general && !at_target)
                begin
                    ctrl.shift = 1'b1;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    ctrl.clear = 1'b1;
                end
            end
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (accept && is_last)
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                if (emit)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_COLLECT;
            count_reg    <= '0;
            scan_reg     <= '0;
            largest_reg  <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                count_reg    <= '0;
                scan_reg     <= '0;
                largest_reg  <= '0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                if (ctrl.shift)
                begin
                    scan_reg <= scan_reg + CNT_W'(1);
                end
                if (accept)
                begin
                    if (room)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        if (sample_value > largest_reg)
                        begin
                            largest_reg <= sample_value;
                        end
                    end
                    else
                    begin
                        overflow_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_reg     <= res_found;
            threshold_reg <= res_threshold;
        end
    end

    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign threshold    = threshold_reg;

    kts_chain #(
        .DEPTH (MAX_ITEMS)
    ) u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .sample_value (sample_value),
        .head0        (head0),
        .head1        (head1)
    );

endmodule

/* rtl/kts_cell.sv */
// ----------------------------------------------------------------------------
// kts_cell
// one compare-insert cell of the sorted row
// ----------------------------------------------------------------------------
module kts_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kts_pkg::cell_ctrl_t          ctrl,
    input  logic [kts_pkg::VALUE_W-1:0]  sample_value,
    input  kts_pkg::cell_data_t          left_data,
    input  logic                         left_lt,
    input  kts_pkg::cell_data_t          right_data,
    output kts_pkg::cell_data_t          data,
    output logic                         lt
);
    import kts_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    // empty cells count as larger than anything
    assign lt = !valid_reg || (value_reg > sample_value);

    assign data.valid = valid_reg;
    assign data.value = value_reg;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert && lt)
        begin
            if (left_lt)
            begin
                valid_next = left_data.valid;
                value_next = left_data.value;
            end
            else
            begin
                valid_next = 1'b1;
                value_next = sample_value;
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = right_data.valid;
            value_next = right_data.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* rtl/kts_chain.sv */
// ----------------------------------------------------------------------------
// kts_chain
// row of compare-insert cells holding the values in ascending order
// ----------------------------------------------------------------------------
module kts_chain #(
    parameter int DEPTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kts_pkg::cell_ctrl_t          ctrl,
    input  logic [kts_pkg::VALUE_W-1:0]  sample_value,
    output kts_pkg::cell_data_t          head0,
    output kts_pkg::cell_data_t          head1
);
    import kts_pkg::*;

    cell_data_t cell_data [DEPTH];
    logic       cell_lt   [DEPTH];
    cell_data_t empty_data;

    assign empty_data.valid = 1'b0;
    assign empty_data.value = VALUE_MAX;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_data_t left_d;
        cell_data_t right_d;
        logic       left_l;

        if (i == 0)
        begin : g_first
            assign left_d = empty_data;
            assign left_l = 1'b0;
        end
        else
        begin : g_inner_left
            assign left_d = cell_data[i-1];
            assign left_l = cell_lt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = empty_data;
        end
        else
        begin : g_inner_right
            assign right_d = cell_data[i+1];
        end

        kts_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .sample_value (sample_value),
            .left_data    (left_d),
            .left_lt      (left_l),
            .right_data   (right_d),
            .data         (cell_data[i]),
            .lt           (cell_lt[i])
        );
    end

    assign head0 = cell_data[0];
    assign head1 = cell_data[1];

endmodule

/* rtl/kts_checker.sv */
// ----------------------------------------------------------------------------
// kts_checker
// port-level checks for the k-th smallest threshold selector
// ----------------------------------------------------------------------------
module kts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        sample_valid,
    input logic        sample_ready,
    input logic        is_last,
    input logic        result_valid,
    input logic        result_ready,
    input logic        found,
    input logic [31:0] threshold,
    input logic        pready
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(found) && $stable(threshold))
        else $error("result changed while stalled");

    // a result without an answer carries a zero threshold
    a_no_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> threshold == 32'd0)
        else $error("threshold not zero without answer");

    // the set is closed in the cycle after its last item
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && is_last |=> !sample_ready)
        else $error("item taken right after last item");

    // configuration port never stalls
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind kth_smallest_threshold_select kts_checker u_kts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .found        (found),
    .threshold    (threshold),
    .pready       (pready)
);
